>>> hw/rtl/psd_pkg.sv
// shared types and constants for the nearest-prime search block
package psd_pkg;

	// widths of the result and start fields at the ports
	localparam int PV_BITS = 20;
	// default width of the search range
	localparam int VALUE_BITS_DEF = 20;

	// first odd trial divisor and its square
	localparam int FIRST_DIV = 3;
	localparam int FIRST_SQ = 9;
	localparam int SMALLEST_PRIME = 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NEXT,
		ST_CHECK,
		ST_LOOP,
		ST_DIV
	} psd_state_t;

	// status of the shared remainder unit towards the sequencer
	typedef struct packed {
		logic done;
		logic zero;
	} rem_status_t;

endpackage

>>> hw/rtl/prime_search_trial_division.sv
// nearest prime above or below a start value, found by trial division
//
// A request (start high while busy is low) starts a search from start_value, which is itself
// excluded, upward when toward_larger is 1 and downward otherwise. busy stays high for the
// whole search. The result appears on prime_value and none_found for exactly one cycle with
// done high, and must be taken then. none_found is set with prime_value zero when no prime
// lies below the start, or none lies above it within the VALUE_BITS range. Timing depends on
// the data: each odd trial divisor tried on a candidate (up to sqrt(candidate)/2 of them) is
// run through the single bit-serial remainder unit, and every candidate passed before the
// prime adds to the total.
module prime_search_trial_division #(
	parameter int VALUE_BITS = psd_pkg::VALUE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [psd_pkg::PV_BITS-1:0] start_value,
	input  logic                        toward_larger,
	output logic                        done,
	output logic [psd_pkg::PV_BITS-1:0] prime_value,
	output logic                        none_found
);
	import psd_pkg::*;

	localparam int DW = (VALUE_BITS + 1) / 2 + 2;
	localparam int SW = VALUE_BITS + 2;

	psd_state_t            state_q;
	psd_state_t            state_nxt;
	logic [VALUE_BITS-1:0] cand_q;
	logic                  up_q;
	logic [DW-1:0]         div_q;
	logic [SW-1:0]         sq_q;
	logic                  done_q;
	logic [PV_BITS-1:0]    prime_q;
	logic                  none_q;

	logic [VALUE_BITS-1:0] start_ext;
	logic [PV_BITS-1:0]    cand_pv;
	logic                  rem_start;
	rem_status_t           rem_st;

	// control decoded by the sequencer
	logic load_start;
	logic step_cand;
	logic init_div;
	logic next_div;
	logic hit;
	logic miss;

	generate
		if (VALUE_BITS > PV_BITS) begin : g_wide
			assign start_ext = {{(VALUE_BITS - PV_BITS){1'b0}}, start_value};
			assign cand_pv = cand_q[PV_BITS-1:0];
		end else if (VALUE_BITS == PV_BITS) begin : g_same
			assign start_ext = start_value;
			assign cand_pv = cand_q;
		end else begin : g_narrow
			assign start_ext = start_value[VALUE_BITS-1:0];
			assign cand_pv = {{(PV_BITS - VALUE_BITS){1'b0}}, cand_q};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		load_start = 1'b0;
		step_cand = 1'b0;
		init_div = 1'b0;
		next_div = 1'b0;
		hit = 1'b0;
		miss = 1'b0;
		rem_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					load_start = 1'b1;
					state_nxt = ST_NEXT;
				end
			end
			ST_NEXT: begin
				// stop at the range top going up, at the smallest prime going down
				if (up_q ? (cand_q == '1)
				         : (cand_q <= VALUE_BITS'(SMALLEST_PRIME))) begin
					miss = 1'b1;
					state_nxt = ST_IDLE;
				end else begin
					step_cand = 1'b1;
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (cand_q == VALUE_BITS'(SMALLEST_PRIME)) begin
					hit = 1'b1;
					state_nxt = ST_IDLE;
				end else if (cand_q < VALUE_BITS'(SMALLEST_PRIME) || !cand_q[0]) begin
					state_nxt = ST_NEXT;
				end else begin
					init_div = 1'b1;
					state_nxt = ST_LOOP;
				end
			end
			ST_LOOP: begin
				if (sq_q > {2'b00, cand_q}) begin
					hit = 1'b1;
					state_nxt = ST_IDLE;
				end else begin
					rem_start = 1'b1;
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				if (rem_st.done) begin
					if (rem_st.zero) begin
						state_nxt = ST_NEXT;
					end else begin
						next_div = 1'b1;
						state_nxt = ST_LOOP;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= hit | miss;
		end
	end

	always_ff @(posedge clk) begin
		if (load_start) begin
			cand_q <= start_ext;
			up_q <= toward_larger;
		end else if (step_cand) begin
			if (up_q) begin
				cand_q <= cand_q + 1'b1;
			end else begin
				cand_q <= cand_q - 1'b1;
			end
		end
		if (init_div) begin
			div_q <= DW'(FIRST_DIV);
			sq_q <= SW'(FIRST_SQ);
		end else if (next_div) begin
			// (d + 2)^2 = d^2 + 4d + 4
			div_q <= div_q + DW'(2);
			sq_q <= sq_q + SW'({div_q, 2'b00}) + SW'(4);
		end
		if (hit) begin
			prime_q <= cand_pv;
			none_q <= 1'b0;
		end else if (miss) begin
			prime_q <= '0;
			none_q <= 1'b1;
		end
	end

	psd_rem_unit #(
		.VALUE_BITS(VALUE_BITS),
		.DIV_BITS(DW)
	) u_rem (
		.clk(clk),
		.arst_n(arst_n),
		.start(rem_start),
		.dividend(cand_q),
		.divisor(div_q),
		.status(rem_st)
	);

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign prime_value = prime_q;
	assign none_found = none_q;

endmodule

>>> hw/rtl/psd_rem_unit.sv
// bit-serial remainder unit: one dividend bit per cycle, restoring
module psd_rem_unit #(
	parameter int VALUE_BITS = psd_pkg::VALUE_BITS_DEF,
	parameter int DIV_BITS = (psd_pkg::VALUE_BITS_DEF + 1) / 2 + 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_BITS-1:0]  dividend,
	input  logic [DIV_BITS-1:0]    divisor,
	output psd_pkg::rem_status_t   status
);
	import psd_pkg::*;

	localparam int CW = $clog2(VALUE_BITS + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [VALUE_BITS-1:0] dvd_q;
	logic [DIV_BITS-1:0]   dsr_q;
	logic [DIV_BITS-1:0]   rem_q;
	logic [DIV_BITS:0]     rem_sh;
	logic [DIV_BITS:0]     rem_sub;
	logic [DIV_BITS-1:0]   rem_nxt;

	// shift in the next dividend bit and subtract the divisor if it fits
	always_comb begin
		rem_sh = {rem_q, dvd_q[VALUE_BITS-1]};
		rem_sub = rem_sh - {1'b0, dsr_q};
		if (rem_sh >= {1'b0, dsr_q}) begin
			rem_nxt = rem_sub[DIV_BITS-1:0];
		end else begin
			rem_nxt = rem_sh[DIV_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_BITS-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign status.done = done_q;
	assign status.zero = (rem_q == '0);

endmodule
